/* hw/rtl/ppu_pkg.sv */
// Shared types, constants and helper functions of the packed pixel unpacker.
// No dependencies; the interfaces, the top, the front and back ends and the testbench import this package.
`timescale 1ns / 1ps

package ppu_pkg;

  // Input command codes.
  localparam logic [1:0] CMD_PAL   = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_DATA  = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_COLOR = 1'd1;

  localparam int COLOR_W = 24;
  localparam int LEN_W   = 11;

  // Work kinds handed from the front to the back.
  typedef enum logic [1:0] {
    KIND_PAL,
    KIND_START,
    KIND_DATA
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         pal_index;
    logic [COLOR_W-1:0] pal_color;
    logic [2:0]         first_pos;
    logic [LEN_W-1:0]   line_length;
    logic [7:0]         data_byte;
  } work_t;

  // Bit position of the first pixel of a line within its byte.
  function automatic logic [2:0] first_position(logic [1:0] size_lg, logic [2:0] x);
    logic [2:0] pos;
    case (size_lg)
      2'd0:    pos = ~x;
      2'd1:    pos = {~x[1:0], 1'b0};
      2'd2:    pos = {~x[0], 2'b00};
      default: pos = 3'd0;
    endcase
    return pos;
  endfunction

  // Opacity of an alpha-format pixel value; the shifted copies scale by 85 and 17.
  function automatic logic [7:0] alpha_of(logic [1:0] size_lg, logic [7:0] v);
    logic [7:0] a;
    case (size_lg)
      2'd0:    a = (v[0] != 1'b0) ? 8'hFF : 8'h00;
      2'd1:    a = {v[1:0], v[1:0], v[1:0], v[1:0]};
      2'd2:    a = {v[3:0], v[3:0]};
      default: a = v;
    endcase
    return a;
  endfunction

endpackage

/* hw/rtl/ppu_in_if.sv */
// Input channel of the packed pixel unpacker: valid/ready plus the item fields.
// Depends on ppu_pkg for field widths.
`timescale 1ns / 1ps

interface ppu_in_if;
  import ppu_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [7:0]         palette_index;
  logic [COLOR_W-1:0] palette_color;
  logic [9:0]         start_x;
  logic [LEN_W-1:0]   line_length;
  logic [7:0]         data_byte;

  modport source (output valid, cmd, palette_index, palette_color, start_x,
                  line_length, data_byte, input ready);
  modport sink   (input valid, cmd, palette_index, palette_color, start_x,
                  line_length, data_byte, output ready);
endinterface

/* hw/rtl/ppu_out_if.sv */
// Result channel of the packed pixel unpacker: valid/ready plus one pixel.
// Depends on ppu_pkg for field widths.
`timescale 1ns / 1ps

interface ppu_out_if;
  import ppu_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_color;
  logic [7:0]         pixel_alpha;
  logic               last_of_byte;
  logic               last_of_line;

  modport source (output valid, pixel_color, pixel_alpha, last_of_byte, last_of_line,
                  input ready);
  modport sink   (input valid, pixel_color, pixel_alpha, last_of_byte, last_of_line,
                  output ready);
endinterface

/* hw/rtl/packed_pixel_unpacker.sv */
// Packed pixel unpacker: expands 1/2/4/8 bpp packed pixels of an image line into
// RGB888 colour and 8-bit opacity, using a palette for indexed formats.
//
// Channels: in_chan carries palette writes, start-line commands and packed data
// bytes; out_chan carries one pixel per transaction with end-of-byte and
// end-of-line flags. Both use valid/ready; a transaction completes when both are
// high at a rising edge. The user must write registers through cfg_we/cfg_addr/cfg_wdata
// only while the block is idle; the block itself does not enforce this.
// Throughput: one pixel per cycle while the output is not stalled, so a data byte yields
// 8 / bpp pixels (fewer if the line starts or ends inside it); palette writes,
// start-line commands and ignored bytes produce no pixel. The single pixel datapath
// with its palette read port sets this figure. With the queue empty and the output
// register free, an accepted transaction passes the queue slot and then the output
// register, where the palette read and the output register load at the same edge.
// A four-entry queue decouples input from output, so input keeps flowing while
// the receiver stalls until the queue fills. Reset clears the queue, the line
// state and the registers; palette contents are undefined until written.
// Depends on ppu_pkg, ppu_in_if, ppu_out_if, ppu_front, ppu_queue, ppu_back.
`timescale 1ns / 1ps

module packed_pixel_unpacker #(
  parameter int PALETTE_DEPTH = 256,
  parameter int MAX_LINE      = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  ppu_in_if.sink                             in_chan,
  ppu_out_if.source                          out_chan,
  input  logic                               cfg_we,
  input  logic [ppu_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [ppu_pkg::COLOR_W-1:0]        cfg_wdata
);
  import ppu_pkg::*;

  logic [2:0]         pixel_format_r;
  logic [COLOR_W-1:0] background_color_r;

  logic   push, full, pop, empty;
  work_t  push_data, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_format_r     <= '0;
      background_color_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PIXEL_FORMAT:     pixel_format_r     <= cfg_wdata[2:0];
        REG_BACKGROUND_COLOR: background_color_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ppu_front #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_front (
    .in_chan      (in_chan),
    .pixel_format (pixel_format_r),
    .queue_full   (full),
    .push         (push),
    .push_data    (push_data)
  );

  ppu_queue #(
    .T     (work_t),
    .DEPTH (4)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  ppu_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .MAX_LINE      (MAX_LINE)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pixel_format     (pixel_format_r),
    .background_color (background_color_r),
    .head             (head),
    .empty            (empty),
    .pop              (pop),
    .out_chan         (out_chan)
  );

endmodule

/* hw/rtl/ppu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ppu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/ppu_queue.sv */
// Small FIFO that carries classified work from the front to the back.
// Depends on ppu_pkg only through the element type handed in.
`timescale 1ns / 1ps

module ppu_queue #(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     push_data,
  output logic full,
  input  logic pop,
  output T     head,
  output logic empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  T               slots_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic           do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign head    = slots_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

/* hw/rtl/ppu_front.sv */
// Front end: accepts input transactions, drops unused commands and out-of-range palette
// writes, and classifies the rest into work entries for the queue. Depends on ppu_pkg, ppu_in_if.
`timescale 1ns / 1ps

module ppu_front #(
  parameter int PALETTE_DEPTH = 256
) (
  ppu_in_if.sink           in_chan,
  input  logic [2:0]       pixel_format,
  input  logic             queue_full,
  output logic             push,
  output ppu_pkg::work_t   push_data
);
  import ppu_pkg::*;

  logic keep;

  assign in_chan.ready = !queue_full;

  // Unused commands and palette writes beyond the palette are swallowed here.
  always_comb begin
    push_data.pal_index   = in_chan.palette_index;
    push_data.pal_color   = in_chan.palette_color;
    push_data.first_pos   = first_position(pixel_format[1:0], in_chan.start_x[2:0]);
    push_data.line_length = in_chan.line_length;
    push_data.data_byte   = in_chan.data_byte;
    keep                  = 1'b1;
    case (in_chan.cmd)
      CMD_PAL: begin
        push_data.kind = KIND_PAL;
        keep           = (32'(in_chan.palette_index) < 32'(PALETTE_DEPTH));
      end
      CMD_START: begin
        push_data.kind = KIND_START;
      end
      CMD_DATA: begin
        push_data.kind = KIND_DATA;
      end
      default: begin
        push_data.kind = KIND_DATA;
        keep           = 1'b0;
      end
    endcase
  end

  assign push = in_chan.valid && !queue_full && keep;

endmodule

/* hw/rtl/ppu_back.sv */
// Back end: runs queued work in order, writes the palette and unpacks one pixel per cycle,
// while the output is not stalled, into the output register. Depends on ppu_pkg, ppu_ram, ppu_out_if.
`timescale 1ns / 1ps

module ppu_back #(
  parameter int PALETTE_DEPTH = 256,
  parameter int MAX_LINE      = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [2:0]              pixel_format,
  input  logic [ppu_pkg::COLOR_W-1:0] background_color,
  input  ppu_pkg::work_t          head,
  input  logic                    empty,
  output logic                    pop,
  ppu_out_if.source               out_chan
);
  import ppu_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int LW = $clog2(MAX_LINE + 1);

  logic [2:0]    bit_pos_r, bit_pos_nxt;
  logic [LW-1:0] left_r, left_nxt;
  logic          ob_valid_r, ob_valid_nxt;
  logic [7:0]    ob_alpha_r, ob_alpha_nxt;
  logic          ob_lastb_r, ob_lastb_nxt;
  logic          ob_lastl_r, ob_lastl_nxt;
  logic          ob_indexed_r, ob_indexed_nxt;
  logic          ob_inrange_r, ob_inrange_nxt;

  logic [3:0]         size;
  logic [2:0]         size_m1;
  logic [7:0]         mask;
  logic [2:0]         pos;
  logic [7:0]         value;
  logic               end_byte, end_line;
  logic               advance, emit, pal_we;
  logic [COLOR_W-1:0] pal_q;

  assign size    = 4'd1 << pixel_format[1:0];
  assign size_m1 = 3'(size - 4'd1);
  assign mask    = 8'((9'd1 << size) - 9'd1);
  // Rounding down covers a format change in the middle of a line.
  assign pos      = bit_pos_r & ~size_m1;
  assign value    = (head.data_byte >> pos) & mask;
  assign end_byte = ({1'b0, pos} < size);
  assign end_line = (left_r == LW'(1));

  assign advance = !ob_valid_r || out_chan.ready;
  assign pal_we  = !empty && (head.kind == KIND_PAL);
  assign emit    = !empty && (head.kind == KIND_DATA) && (left_r != '0) && advance;

  always_comb begin
    bit_pos_nxt    = bit_pos_r;
    left_nxt       = left_r;
    pop            = 1'b0;
    ob_valid_nxt   = ob_valid_r;
    ob_alpha_nxt   = ob_alpha_r;
    ob_lastb_nxt   = ob_lastb_r;
    ob_lastl_nxt   = ob_lastl_r;
    ob_indexed_nxt = ob_indexed_r;
    ob_inrange_nxt = ob_inrange_r;
    if (advance) begin
      ob_valid_nxt = emit;
    end
    if (!empty) begin
      case (head.kind)
        KIND_PAL: begin
          pop = 1'b1;
        end
        KIND_START: begin
          pop         = 1'b1;
          bit_pos_nxt = head.first_pos;
          if (32'(head.line_length) > 32'(MAX_LINE)) begin
            left_nxt = LW'(MAX_LINE);
          end else begin
            left_nxt = LW'(head.line_length);
          end
        end
        KIND_DATA: begin
          if (left_r == '0) begin
            pop = 1'b1;
          end else if (emit) begin
            left_nxt       = left_r - LW'(1);
            bit_pos_nxt    = end_byte ? 3'(4'd8 - size) : pos - size_m1 - 3'd1;
            pop            = end_byte || end_line;
            ob_alpha_nxt   = pixel_format[2] ? 8'hFF : alpha_of(pixel_format[1:0], value);
            ob_lastb_nxt   = end_byte || end_line;
            ob_lastl_nxt   = end_line;
            ob_indexed_nxt = pixel_format[2];
            ob_inrange_nxt = (32'(value) < 32'(PALETTE_DEPTH));
          end
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_pos_r  <= '0;
      left_r     <= '0;
      ob_valid_r <= 1'b0;
    end else begin
      bit_pos_r  <= bit_pos_nxt;
      left_r     <= left_nxt;
      ob_valid_r <= ob_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ob_alpha_r   <= ob_alpha_nxt;
    ob_lastb_r   <= ob_lastb_nxt;
    ob_lastl_r   <= ob_lastl_nxt;
    ob_indexed_r <= ob_indexed_nxt;
    ob_inrange_r <= ob_inrange_nxt;
  end

  // The read data register only loads on emit, so it holds while the output stalls.
  ppu_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .we      (pal_we),
    .waddr   (head.pal_index[AW-1:0]),
    .wdata   (head.pal_color),
    .re      (emit),
    .raddr   (value[AW-1:0]),
    .rdata_r (pal_q)
  );

  assign out_chan.valid        = ob_valid_r;
  assign out_chan.pixel_alpha  = ob_alpha_r;
  assign out_chan.last_of_byte = ob_lastb_r;
  assign out_chan.last_of_line = ob_lastl_r;
  assign out_chan.pixel_color  = !ob_indexed_r ? background_color :
                                 (ob_inrange_r ? pal_q : '0);

endmodule

/* test/testbench.sv */
// Self-checking testbench for packed_pixel_unpacker: drives palette, line and data
// transactions with random idling and checks every pixel against an in-bench predictor.
// Depends on ppu_pkg, ppu_in_if, ppu_out_if and the packed_pixel_unpacker RTL.
`timescale 1ns / 1ps

module testbench;
  import ppu_pkg::*;

  localparam int PALETTE_DEPTH  = 256;
  localparam int MAX_LINE       = 1024;
  localparam int DRAIN_CYCLES   = 16;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 11;
  localparam int PHASE_ITEMS    = 16;

  // The fourth command code is unused by the block and must be ignored.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    FMT_ALPHA1, FMT_ALPHA2, FMT_ALPHA4, FMT_ALPHA8,
    FMT_INDEX1, FMT_INDEX2, FMT_INDEX4, FMT_INDEX8
  } pixel_format_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         pal_index;
    logic [COLOR_W-1:0] pal_color;
    logic [9:0]         start_x;
    logic [LEN_W-1:0]   line_len;
    logic [7:0]         data;
  } unpacker_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [7:0]         alpha;
    logic               last_byte;
    logic               last_line;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [COLOR_W-1:0]   cfg_wdata;

  ppu_in_if  in_chan ();
  ppu_out_if out_chan ();

  packed_pixel_unpacker #(
    .PALETTE_DEPTH(PALETTE_DEPTH),
    .MAX_LINE     (MAX_LINE)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Predictor state: its own copy of the registers, the palette and the line state.
  pixel_format_t      model_format = FMT_ALPHA1;
  logic [COLOR_W-1:0] model_bg = '0;
  logic [COLOR_W-1:0] model_palette [PALETTE_DEPTH];
  int                 model_bitpos = 0;
  int                 model_left = 0;

  pixel_t expected_pixels [$];

  bit entry_written [PALETTE_DEPTH];
  bit formats_seen [8];
  int items_sent = 0;
  int pixels_checked = 0;
  int n_errors = 0;
  int idle_cycles = 0;
  int hold_cycles_req = 0;
  bit no_idle = 1'b0;

  // Works out the pixels that one accepted transaction produces.
  task automatic predict_pixels(input unpacker_item_t it);
    int size;
    int mask;
    int pos;
    int v;
    bit end_byte;
    bit end_line;
    bit done;
    pixel_t px;
    size = 1 << (int'(model_format) & 3);
    mask = (1 << size) - 1;
    case (it.cmd)
      CMD_PAL: model_palette[it.pal_index] = it.pal_color;
      CMD_START: begin
        model_left = (it.line_len > MAX_LINE) ? MAX_LINE : int'(it.line_len);
        case (size)
          1:       model_bitpos = 7 - int'(it.start_x[2:0]);
          2:       model_bitpos = 6 - 2 * int'(it.start_x[1:0]);
          4:       model_bitpos = 4 - 4 * int'(it.start_x[0]);
          default: model_bitpos = 0;
        endcase
      end
      CMD_DATA: begin
        if (model_left != 0) begin
          // A format change mid line leaves the position unaligned; round it down.
          pos = model_bitpos & ~(size - 1);
          done = 1'b0;
          while (!done) begin
            v = (int'(it.data) >> pos) & mask;
            if (model_format >= FMT_INDEX1) begin
              px.color = model_palette[v];
              px.alpha = 8'd255;
            end else begin
              px.color = model_bg;
              case (model_format)
                FMT_ALPHA1: px.alpha = (v != 0) ? 8'd255 : 8'd0;
                FMT_ALPHA2: px.alpha = 8'(v * 85);
                FMT_ALPHA4: px.alpha = 8'(v * 17);
                default:    px.alpha = 8'(v);
              endcase
            end
            model_left--;
            end_line = (model_left == 0);
            end_byte = (pos < size);
            pos = end_byte ? 8 - size : pos - size;
            px.last_byte = end_byte | end_line;
            px.last_line = end_line;
            expected_pixels.push_back(px);
            done = end_byte | end_line;
          end
          model_bitpos = pos & 7;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : input_monitor
    unpacker_item_t seen;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      seen.cmd       = in_chan.cmd;
      seen.pal_index = in_chan.palette_index;
      seen.pal_color = in_chan.palette_color;
      seen.start_x   = in_chan.start_x;
      seen.line_len  = in_chan.line_length;
      seen.data      = in_chan.data_byte;
      predict_pixels(seen);
    end
  end

  always @(posedge clk) begin : pixel_checker
    pixel_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel: pixel_color %h pixel_alpha %h", out_chan.pixel_color,
               out_chan.pixel_alpha);
        n_errors++;
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (out_chan.pixel_color !== want.color) begin
          $error("pixel_color expected %h actual %h", want.color, out_chan.pixel_color);
          n_errors++;
        end
        if (out_chan.pixel_alpha !== want.alpha) begin
          $error("pixel_alpha expected %h actual %h", want.alpha, out_chan.pixel_alpha);
          n_errors++;
        end
        if (out_chan.last_of_byte !== want.last_byte) begin
          $error("last_of_byte expected %b actual %b", want.last_byte, out_chan.last_of_byte);
          n_errors++;
        end
        if (out_chan.last_of_line !== want.last_line) begin
          $error("last_of_line expected %b actual %b", want.last_line, out_chan.last_of_line);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles, %0d pixels still expected",
               idle_cycles, expected_pixels.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random stalls per pixel, plus a long hold-off when one is requested.
  initial begin : result_sink
    int stall;
    int held;
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_cycles_req > 0) begin
        held = hold_cycles_req;
        hold_cycles_req = 0;
        out_chan.ready <= 1'b0;
        repeat (held) @(posedge clk);
      end
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
    end
  end

  // Valid is left high after a transaction; the next call lowers it only for a gap.
  task automatic send_item(input unpacker_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.cmd           <= it.cmd;
    in_chan.palette_index <= it.pal_index;
    in_chan.palette_color <= it.pal_color;
    in_chan.start_x       <= it.start_x;
    in_chan.line_length   <= it.line_len;
    in_chan.data_byte     <= it.data;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    if (it.cmd != CMD_UNUSED)
      items_sent++;
  endtask

  // Fields a command does not use carry random values; the block must ignore them.
  function automatic unpacker_item_t random_fields();
    unpacker_item_t it;
    it.cmd       = CMD_UNUSED;
    it.pal_index = 8'($urandom);
    it.pal_color = COLOR_W'($urandom);
    it.start_x   = 10'($urandom);
    it.line_len  = LEN_W'($urandom);
    it.data      = 8'($urandom);
    return it;
  endfunction

  task automatic send_palette(input int idx, input logic [COLOR_W-1:0] color);
    unpacker_item_t it;
    it = random_fields();
    it.cmd = CMD_PAL;
    it.pal_index = 8'(idx);
    it.pal_color = color;
    entry_written[idx] = 1'b1;
    send_item(it);
  endtask

  task automatic send_start(input int x, input int len);
    unpacker_item_t it;
    it = random_fields();
    it.cmd = CMD_START;
    it.start_x = 10'(x);
    it.line_len = LEN_W'(len);
    send_item(it);
  endtask

  task automatic send_data(input logic [7:0] b);
    unpacker_item_t it;
    it = random_fields();
    it.cmd = CMD_DATA;
    it.data = b;
    send_item(it);
  endtask

  // In 8 bpp indexed mode a byte is a palette index, so only written entries are used.
  function automatic logic [7:0] pick_data_byte();
    int b;
    b = $urandom_range(0, 255);
    if (model_format == FMT_INDEX8) begin
      while (!entry_written[b]) b = $urandom_range(0, 255);
    end
    return 8'(b);
  endfunction

  // One edge passes first so the monitor has predicted the last accepted transaction.
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input pixel_format_t fmt, input logic [COLOR_W-1:0] color);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_PIXEL_FORMAT;
    cfg_wdata <= COLOR_W'(fmt);
    @(posedge clk);
    cfg_addr  <= REG_BACKGROUND_COLOR;
    cfg_wdata <= color;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_format = fmt;
    model_bg = color;
    formats_seen[fmt] = 1'b1;
  endtask

  // Data with no line open and the unused command must both be dropped silently.
  task automatic test_ignored_items();
    send_data(8'hFF);
    send_item(random_fields());
  endtask

  task automatic test_alpha_formats();
    configure(FMT_ALPHA1, 24'hFFFFFF);
    send_start(3, 12);
    send_data(8'hA5);
    send_data(8'hFF);
    // A saturated long line that stays open across the following format changes.
    configure(FMT_ALPHA2, 24'h000000);
    send_start(5, 2047);
    send_data(8'h1B);
    configure(FMT_ALPHA4, 24'h5A5A5A);
    send_data(8'hF0);
    configure(FMT_ALPHA8, 24'hFFFFFF);
    send_data(8'h80);
    send_data(8'hFF);
    send_start(0, 1);
    send_data(8'h00);
  endtask

  task automatic test_indexed_formats();
    configure(FMT_INDEX4, 24'hFFFFFF);
    send_palette(0, 24'h000000);
    send_palette(15, 24'hFFFFFF);
    send_palette(255, 24'hA5C3E1);
    send_start(1, 3);
    send_data(8'hF0);
    send_data(8'h0F);
    configure(FMT_INDEX8, 24'h000000);
    send_start(1023, 2047);
    send_data(8'hFF);
    send_data(8'h00);
    // A zero-length line owes no pixels, so the byte after it is dropped.
    send_start(0, 0);
    send_data(8'hFF);
  endtask

  task automatic test_palette_fill();
    for (int i = 0; i < 16; i++)
      send_palette(i, COLOR_W'($urandom));
  endtask

  task automatic test_output_stall();
    configure(FMT_ALPHA1, COLOR_W'($urandom));
    hold_cycles_req = HOLD_CYCLES;
    no_idle = 1'b1;
    send_start(0, 64);
    repeat (8) send_data(8'($urandom));
    no_idle = 1'b0;
  endtask

  task automatic send_random_line();
    int r;
    int len;
    int eff;
    int ppb;
    int n_bytes;
    r = $urandom_range(0, 19);
    if (r == 0)
      len = 0;
    else if (r == 1)
      len = $urandom_range(MAX_LINE + 1, 2047);
    else if (r == 2)
      len = MAX_LINE;
    else
      len = $urandom_range(1, 24);
    send_start($urandom_range(0, 1023), len);
    eff = (len > MAX_LINE) ? MAX_LINE : len;
    ppb = 8 >> (int'(model_format) & 3);
    n_bytes = (eff + ppb - 1) / ppb + $urandom_range(0, 1);
    if (n_bytes > 10)
      n_bytes = $urandom_range(2, 10);
    repeat (n_bytes) begin
      if ($urandom_range(0, 15) == 0)
        send_palette($urandom_range(0, 255), COLOR_W'($urandom));
      send_data(pick_data_byte());
    end
  endtask

  task automatic test_random_lines();
    int sel;
    int first_item;
    pixel_format_t fmt;
    logic [COLOR_W-1:0] color;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      fmt = (ph == 0) ? FMT_ALPHA1 : (ph == 1) ? FMT_INDEX8 :
            pixel_format_t'($urandom_range(0, 7));
      color = (ph == 0) ? 24'h000000 : (ph == 1) ? 24'hFFFFFF : COLOR_W'($urandom);
      configure(fmt, color);
      no_idle = (ph == 3 || ph == 7);
      first_item = items_sent;
      while (items_sent - first_item < PHASE_ITEMS) begin
        sel = $urandom_range(0, 9);
        if (sel < 7)
          send_random_line();
        else if (sel == 7)
          send_palette($urandom_range(0, 255), COLOR_W'($urandom));
        else if (sel == 8)
          send_item(random_fields());
        else
          send_data(pick_data_byte());
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin : stimulus
    int n_formats;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    in_chan.valid         = 1'b0;
    in_chan.cmd           = CMD_PAL;
    in_chan.palette_index = '0;
    in_chan.palette_color = '0;
    in_chan.start_x       = '0;
    in_chan.line_length   = '0;
    in_chan.data_byte     = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_ignored_items();
    test_alpha_formats();
    test_indexed_formats();
    test_palette_fill();
    test_output_stall();
    test_random_lines();
    wait_idle();

    n_formats = 0;
    foreach (formats_seen[i]) n_formats += formats_seen[i];
    $display("Run covered %0d input transactions and %0d checked pixels", items_sent,
             pixels_checked);
    $display("over %0d of 8 pixel formats, including one long result-side hold-off.",
             n_formats);
    if (n_errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/ppu_pkg.sv
hw/rtl/ppu_in_if.sv
hw/rtl/ppu_out_if.sv
hw/rtl/ppu_ram.sv
hw/rtl/ppu_queue.sv
hw/rtl/ppu_front.sv
hw/rtl/ppu_back.sv
hw/rtl/packed_pixel_unpacker.sv
test/testbench.sv
